FILE: hw/rtl/urbe_pkg.sv
// Shared constants and types for the serial port ring buffer engine.
`timescale 1ns / 1ps

package urbe_pkg;

  // Default depth of each byte store
  localparam int unsigned DEF_STORE_DEPTH = 256;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned CFG_INDEX_W = 1;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_RX_BYTE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TX_READY = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SW_WRITE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SW_POP   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SW_PEEK  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_START    = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_RX_RING_SIZE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TX_RING_SIZE = 1'd1;

  localparam logic [BYTE_W-1:0] RING_SIZE_RESET = 8'd128;

  // Result of the shared modulo unit
  typedef struct packed {
    logic              done;
    logic [BYTE_W-1:0] rem;
  } urbe_mod_res_t;

endpackage

FILE: hw/rtl/urbe_mod_unit.sv
// Bit-serial 8-bit modulo unit: one restoring step per cycle.
`timescale 1ns / 1ps

module urbe_mod_unit
  import urbe_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [BYTE_W-1:0]   dividend,
  input  logic [BYTE_W-1:0]   divisor,
  output urbe_mod_res_t       res
);

  localparam int unsigned CNT_W = $clog2(BYTE_W);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [BYTE_W-1:0]   rem;
  logic [BYTE_W-1:0]   dvd;
  logic [BYTE_W-1:0]   dsr;
  logic                done;
  logic [BYTE_W:0]     trial;
  logic [BYTE_W-1:0]   rem_next;

  // Shift in the next dividend bit, subtract where it fits
  // (a zero divisor leaves the dividend itself as the remainder)
  always_comb begin
    trial = {rem, dvd[BYTE_W-1]};
    if (trial >= {1'b0, dsr}) begin
      rem_next = BYTE_W'(trial - {1'b0, dsr});
    end else begin
      rem_next = trial[BYTE_W-1:0];
    end
  end

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(BYTE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand and remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[BYTE_W-2:0], 1'b0};
    end
  end

  assign res = {done, rem};

endmodule

FILE: hw/rtl/uart_ring_buffer_engine.sv
// Top level of the serial port ring buffer engine: sequencer, stores and result register.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------------------
//  in       | in_valid / in_stall     | kind, byte_value
//  out      | out_valid / out_stall   | read_byte, read_valid, line_byte, line_valid,
//           |                         | rx_count, tx_count, tx_enabled, sent_flag, busy_flag
//  cfg      | cfg_write               | cfg_index, cfg_data
//
// Each transaction passes from acceptance to result through the bit-serial modulo unit
// that maps the pointer to its slot, a step that hands the remainder to the sequencer,
// the store access and the load of the result register. The next item is taken the
// cycle after the load; a result waiting in the output register does not hold up
// acceptance, only the next load. Reset (rst, synchronous) clears pointers and flags;
// the stores need no clearing pass. A stalled result register holds its contents until
// taken.
`timescale 1ns / 1ps

module uart_ring_buffer_engine
  import urbe_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = DEF_STORE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [KIND_W-1:0]      kind,
  input  logic [BYTE_W-1:0]      byte_value,
  // Output channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [BYTE_W-1:0]      read_byte,
  output logic                   read_valid,
  output logic [BYTE_W-1:0]      line_byte,
  output logic                   line_valid,
  output logic [BYTE_W-1:0]      rx_count,
  output logic [BYTE_W-1:0]      tx_count,
  output logic                   tx_enabled,
  output logic                   sent_flag,
  output logic                   busy_flag,
  // Configuration
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]      cfg_data
);

  localparam int unsigned AW       = $clog2(STORE_DEPTH);
  localparam int unsigned PTR_VALS = 1 << BYTE_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_MEM  = 2'd2;
  localparam logic [1:0] S_DATA = 2'd3;

  logic [1:0]          state;
  logic [1:0]          state_next;

  logic [BYTE_W-1:0]   rx_ring_size;
  logic [BYTE_W-1:0]   tx_ring_size;
  logic [BYTE_W-1:0]   rx_head;
  logic [BYTE_W-1:0]   rx_tail;
  logic [BYTE_W-1:0]   tx_head;
  logic [BYTE_W-1:0]   tx_tail;
  logic                send_enable;
  logic                drained;
  logic                in_use;

  logic [KIND_W-1:0]   kind_q;
  logic [BYTE_W-1:0]   byte_q;
  logic                line_hit;
  logic                read_hit;

  logic [BYTE_W-1:0]   rx_mem [STORE_DEPTH];
  logic [BYTE_W-1:0]   tx_mem [STORE_DEPTH];
  logic [BYTE_W-1:0]   rx_rd;
  logic [BYTE_W-1:0]   tx_rd;

  logic [AW-1:0]       slot_table [PTR_VALS];
  logic [AW-1:0]       slot;

  logic                in_take;
  logic                out_free;
  logic [BYTE_W-1:0]   mod_ptr;
  logic [BYTE_W-1:0]   mod_size;
  urbe_mod_res_t       mod_res;
  logic                tx_empty;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign tx_empty = (tx_head == tx_tail);

  // Fold a ring slot onto the store depth
  for (genvar g = 0; g < PTR_VALS; g++) begin : g_slot
    assign slot_table[g] = AW'(g % STORE_DEPTH);
  end
  assign slot = slot_table[mod_res.rem];

  // Pick the pointer and ring size for the incoming transaction
  always_comb begin
    mod_ptr  = '0;
    mod_size = tx_ring_size;
    case (kind)
      KIND_RX_BYTE: begin
        mod_ptr  = rx_head;
        mod_size = rx_ring_size;
      end
      KIND_SW_POP, KIND_SW_PEEK: begin
        mod_ptr  = rx_tail;
        mod_size = rx_ring_size;
      end
      KIND_TX_READY: mod_ptr = tx_tail;
      KIND_SW_WRITE: mod_ptr = tx_head;
      default:       mod_ptr = '0;
    endcase
  end

  urbe_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (in_take),
    .dividend (mod_ptr),
    .divisor  (mod_size),
    .res      (mod_res)
  );

  // Advance the sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_take) state_next = S_DIV;
      S_DIV:   if (mod_res.done) state_next = S_MEM;
      S_MEM:   state_next = S_DATA;
      S_DATA:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the accepted transaction
  always_ff @(posedge clk) begin
    if (in_take) begin
      kind_q <= kind;
      byte_q <= byte_value;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_ring_size <= RING_SIZE_RESET;
      tx_ring_size <= RING_SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RX_RING_SIZE: rx_ring_size <= cfg_data;
        REG_TX_RING_SIZE: tx_ring_size <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Stores: write on push, read both at the slot
  always_ff @(posedge clk) begin
    if (state == S_MEM) begin
      if (kind_q == KIND_RX_BYTE) begin
        rx_mem[slot] <= byte_q;
      end
      if (kind_q == KIND_SW_WRITE) begin
        tx_mem[slot] <= byte_q;
      end
      rx_rd <= rx_mem[slot];
      tx_rd <= tx_mem[slot];
    end
  end

  // Update pointers and send flags
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head     <= '0;
      rx_tail     <= '0;
      tx_head     <= '0;
      tx_tail     <= '0;
      send_enable <= 1'b0;
      drained     <= 1'b0;
      in_use      <= 1'b0;
      line_hit    <= 1'b0;
      read_hit    <= 1'b0;
    end else if (state == S_MEM) begin
      line_hit <= 1'b0;
      read_hit <= 1'b0;
      case (kind_q)
        KIND_RX_BYTE: rx_head <= rx_head + 1'b1;
        KIND_TX_READY: begin
          if (send_enable) begin
            if (tx_empty) begin
              send_enable <= 1'b0;
              drained     <= 1'b1;
              in_use      <= 1'b0;
            end else begin
              tx_tail  <= tx_tail + 1'b1;
              line_hit <= 1'b1;
            end
          end
        end
        KIND_SW_WRITE: tx_head <= tx_head + 1'b1;
        KIND_SW_POP: begin
          rx_tail  <= rx_tail + 1'b1;
          read_hit <= 1'b1;
        end
        KIND_SW_PEEK: read_hit <= 1'b1;
        KIND_START: begin
          send_enable <= 1'b1;
          drained     <= 1'b0;
          in_use      <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DATA && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DATA && out_free) begin
      read_byte  <= read_hit ? rx_rd : '0;
      read_valid <= read_hit;
      line_byte  <= line_hit ? tx_rd : '0;
      line_valid <= line_hit;
      rx_count   <= rx_head - rx_tail;
      tx_count   <= tx_head - tx_tail;
      tx_enabled <= send_enable;
      sent_flag  <= drained;
      busy_flag  <= in_use;
    end
  end

  // Checks
  a_mod_done_in_div: assert property (@(posedge clk) disable iff (rst)
    mod_res.done |-> state == S_DIV)
    else $error("modulo result outside the divide phase");

  a_one_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(read_valid && line_valid))
    else $error("read and line result in one transaction");

  a_flags_agree: assert property (@(posedge clk) disable iff (rst)
    !(drained && send_enable) && (in_use == send_enable))
    else $error("send flags inconsistent");

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |=> (state == S_DIV || state == S_MEM))
    else $error("sequencer left the divide phase early");

endmodule

FILE: tb/urbe_checker.sv
// Result checker for the serial port ring buffer engine: predicts and compares each result.
`timescale 1ns / 1ps

module urbe_checker
  import urbe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [KIND_W-1:0]      kind,
  input  logic [BYTE_W-1:0]      byte_value,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [BYTE_W-1:0]      read_byte,
  input  logic                   read_valid,
  input  logic [BYTE_W-1:0]      line_byte,
  input  logic                   line_valid,
  input  logic [BYTE_W-1:0]      rx_count,
  input  logic [BYTE_W-1:0]      tx_count,
  input  logic                   tx_enabled,
  input  logic                   sent_flag,
  input  logic                   busy_flag,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]      cfg_data,
  output int                     fail_count,
  output int                     pending
);

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic              read_valid;
    logic [BYTE_W-1:0] line_byte;
    logic              line_valid;
    logic [BYTE_W-1:0] rx_count;
    logic [BYTE_W-1:0] tx_count;
    logic              tx_enabled;
    logic              sent_flag;
    logic              busy_flag;
  } ring_status_t;

  // Own copy of the rings, pointers, flags and ring sizes
  logic [BYTE_W-1:0] rx_mem [DEF_STORE_DEPTH];
  logic [BYTE_W-1:0] tx_mem [DEF_STORE_DEPTH];
  logic [BYTE_W-1:0] rx_size, tx_size;
  logic [BYTE_W-1:0] rx_wr, rx_rd, tx_wr, tx_rd;
  logic              sending, drained_q, in_use_q;

  ring_status_t status_due [$];

  // Map a free-running pointer to its slot; size zero leaves the pointer as it is
  function automatic int unsigned slot_of_ptr(input logic [BYTE_W-1:0] ptr,
                                              input logic [BYTE_W-1:0] size);
    int unsigned p;
    p = ptr;
    if (size != '0) p = p % size;
    return p % DEF_STORE_DEPTH;
  endfunction

  // Apply one transaction to the rings and return the status it leaves
  function automatic ring_status_t step_rings(input logic [KIND_W-1:0] k,
                                              input logic [BYTE_W-1:0] b);
    ring_status_t r;
    r = '0;
    case (k)
      KIND_RX_BYTE: begin
        rx_mem[slot_of_ptr(rx_wr, rx_size)] = b;
        rx_wr = rx_wr + 1'b1;
      end
      KIND_TX_READY: begin
        if (sending) begin
          if (tx_wr == tx_rd) begin
            // nothing left to send: stop and flag the ring as drained
            sending   = 1'b0;
            drained_q = 1'b1;
            in_use_q  = 1'b0;
          end else begin
            r.line_byte  = tx_mem[slot_of_ptr(tx_rd, tx_size)];
            r.line_valid = 1'b1;
            tx_rd = tx_rd + 1'b1;
          end
        end
      end
      KIND_SW_WRITE: begin
        tx_mem[slot_of_ptr(tx_wr, tx_size)] = b;
        tx_wr = tx_wr + 1'b1;
      end
      KIND_SW_POP: begin
        r.read_byte  = rx_mem[slot_of_ptr(rx_rd, rx_size)];
        r.read_valid = 1'b1;
        rx_rd = rx_rd + 1'b1;
      end
      KIND_SW_PEEK: begin
        r.read_byte  = rx_mem[slot_of_ptr(rx_rd, rx_size)];
        r.read_valid = 1'b1;
      end
      KIND_START: begin
        sending   = 1'b1;
        drained_q = 1'b0;
        in_use_q  = 1'b1;
      end
      default: ;
    endcase
    r.rx_count   = rx_wr - rx_rd;
    r.tx_count   = tx_wr - tx_rd;
    r.tx_enabled = sending;
    r.sent_flag  = drained_q;
    r.busy_flag  = in_use_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                             input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Track configuration, compare results against the oldest prediction, queue new ones
  always @(posedge clk) begin
    ring_status_t due;
    if (rst) begin
      rx_size   = RING_SIZE_RESET;
      tx_size   = RING_SIZE_RESET;
      rx_wr     = '0;
      rx_rd     = '0;
      tx_wr     = '0;
      tx_rd     = '0;
      sending   = 1'b0;
      drained_q = 1'b0;
      in_use_q  = 1'b0;
      status_due.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_RX_RING_SIZE) rx_size = cfg_data;
        else if (cfg_index == REG_TX_RING_SIZE) tx_size = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          $error("result transaction with no prediction waiting");
          fail_count++;
        end else begin
          due = status_due.pop_front();
          check_field("read_byte",  due.read_byte,  read_byte);
          check_field("read_valid", due.read_valid, read_valid);
          check_field("line_byte",  due.line_byte,  line_byte);
          check_field("line_valid", due.line_valid, line_valid);
          check_field("rx_count",   due.rx_count,   rx_count);
          check_field("tx_count",   due.tx_count,   tx_count);
          check_field("tx_enabled", due.tx_enabled, tx_enabled);
          check_field("sent_flag",  due.sent_flag,  sent_flag);
          check_field("busy_flag",  due.busy_flag,  busy_flag);
        end
      end
      if (in_valid && !in_stall) status_due.push_back(step_rings(kind, byte_value));
    end
    pending = status_due.size();
  end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the serial port ring buffer engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import urbe_pkg::*;

  // Kinds the block ignores
  localparam logic [KIND_W-1:0] KIND_RSVD_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD_7 = 3'd7;

  localparam int IDLE_LIMIT      = 2000;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int DRAIN_CYCLES    = 20;

  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   in_valid   = 1'b0;
  logic                   in_stall;
  logic [KIND_W-1:0]      kind       = KIND_RX_BYTE;
  logic [BYTE_W-1:0]      byte_value = '0;
  logic                   out_valid;
  logic                   out_stall  = 1'b0;
  logic [BYTE_W-1:0]      read_byte;
  logic                   read_valid;
  logic [BYTE_W-1:0]      line_byte;
  logic                   line_valid;
  logic [BYTE_W-1:0]      rx_count;
  logic [BYTE_W-1:0]      tx_count;
  logic                   tx_enabled;
  logic                   sent_flag;
  logic                   busy_flag;
  logic                   cfg_write  = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = REG_RX_RING_SIZE;
  logic [BYTE_W-1:0]      cfg_data   = '0;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int stall_left  = 0;
  bit calm_in     = 1'b0;
  bit calm_out    = 1'b0;

  // Pointer shadow kept only so that stimulus never reads a slot that was never written
  logic [BYTE_W-1:0] sh_rx_size = RING_SIZE_RESET;
  logic [BYTE_W-1:0] sh_tx_size = RING_SIZE_RESET;
  logic [BYTE_W-1:0] sh_rx_wr = '0, sh_rx_rd = '0, sh_tx_wr = '0, sh_tx_rd = '0;
  bit                sh_sending = 1'b0;
  bit                rx_filled [DEF_STORE_DEPTH];
  bit                tx_filled [DEF_STORE_DEPTH];

  logic [BYTE_W-1:0] rx_sizes [NUM_PHASES] = '{8'd1, 8'd255, 8'd0, 8'd128,
                                               8'd7, 8'd200, 8'd3, 8'd64};
  logic [BYTE_W-1:0] tx_sizes [NUM_PHASES] = '{8'd255, 8'd1, 8'd0, 8'd128,
                                               8'd3, 8'd5, 8'd254, 8'd16};

  always #2 clk = ~clk;

  uart_ring_buffer_engine dut (.*);

  urbe_checker ring_check (.*);

  function automatic int unsigned slot_for(input logic [BYTE_W-1:0] ptr,
                                           input logic [BYTE_W-1:0] size);
    int unsigned p;
    p = ptr;
    if (size != '0) p = p % size;
    return p % DEF_STORE_DEPTH;
  endfunction

  // True when the transaction reads no slot that is still unwritten
  function automatic bit reads_written(input logic [KIND_W-1:0] k);
    case (k)
      KIND_SW_POP, KIND_SW_PEEK: return rx_filled[slot_for(sh_rx_rd, sh_rx_size)];
      KIND_TX_READY: return !sh_sending || sh_tx_wr == sh_tx_rd ||
                            tx_filled[slot_for(sh_tx_rd, sh_tx_size)];
      default: return 1'b1;
    endcase
  endfunction

  // Offer one transaction after a random gap and hold it until accepted
  task automatic send_txn(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] b);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (calm_in || r < 45) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    byte_value <= b;
    case (k)
      KIND_RX_BYTE: begin
        rx_filled[slot_for(sh_rx_wr, sh_rx_size)] = 1'b1;
        sh_rx_wr++;
      end
      KIND_TX_READY: begin
        if (sh_sending) begin
          if (sh_tx_wr == sh_tx_rd) sh_sending = 1'b0;
          else sh_tx_rd++;
        end
      end
      KIND_SW_WRITE: begin
        tx_filled[slot_for(sh_tx_wr, sh_tx_size)] = 1'b1;
        sh_tx_wr++;
      end
      KIND_SW_POP: sh_rx_rd++;
      KIND_START: sh_sending = 1'b1;
      default: ;
    endcase
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and hold until every predicted result has been taken
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_sizes(input logic [BYTE_W-1:0] rx_sz, input logic [BYTE_W-1:0] tx_sz);
    wait_quiet();
    cfg_write <= 1'b1;
    cfg_index <= REG_RX_RING_SIZE;
    cfg_data  <= rx_sz;
    @(posedge clk);
    cfg_index <= REG_TX_RING_SIZE;
    cfg_data  <= tx_sz;
    @(posedge clk);
    cfg_write <= 1'b0;
    sh_rx_size = rx_sz;
    sh_tx_size = tx_sz;
  endtask

  // Random traffic; bias 0 balanced, 1 filling, 2 draining
  task automatic run_random(input int count, input int bias);
    int effective;
    int r;
    int w_rx, w_ready, w_write, w_pop, w_peek, w_start;
    logic [KIND_W-1:0] k;
    case (bias)
      1:       begin w_rx = 35; w_ready = 10; w_write = 35; w_pop = 8;  w_peek = 4; w_start = 5; end
      2:       begin w_rx = 10; w_ready = 35; w_write = 10; w_pop = 30; w_peek = 5; w_start = 8; end
      default: begin w_rx = 22; w_ready = 22; w_write = 22; w_pop = 14; w_peek = 8; w_start = 8; end
    endcase
    effective = 0;
    while (effective < count) begin
      r = $urandom_range(0, 99);
      if (r < w_rx) k = KIND_RX_BYTE;
      else if (r < w_rx + w_ready) k = KIND_TX_READY;
      else if (r < w_rx + w_ready + w_write) k = KIND_SW_WRITE;
      else if (r < w_rx + w_ready + w_write + w_pop) k = KIND_SW_POP;
      else if (r < w_rx + w_ready + w_write + w_pop + w_peek) k = KIND_SW_PEEK;
      else if (r < w_rx + w_ready + w_write + w_pop + w_peek + w_start) k = KIND_START;
      else k = $urandom_range(0, 1) ? KIND_RSVD_6 : KIND_RSVD_7;
      // replace a read of an unwritten slot by a write to the same ring
      if (!reads_written(k)) k = (k == KIND_TX_READY) ? KIND_SW_WRITE : KIND_RX_BYTE;
      effective++;
      send_txn(k, BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  // Output stalls: mostly short bursts, a few long ones, none in calm phases
  always @(posedge clk) begin
    if (rst || calm_out) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 99) < 12)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part on a two-slot receive ring and a one-slot transmit ring
    write_sizes(8'd2, 8'd1);
    send_txn(KIND_TX_READY, 8'h00);   // ready while sending is off
    send_txn(KIND_RSVD_6, 8'hFF);
    send_txn(KIND_RSVD_7, 8'h00);
    send_txn(KIND_START, 8'hFF);
    send_txn(KIND_TX_READY, 8'hFF);   // ready on an empty ring: stop and mark drained
    send_txn(KIND_RX_BYTE, 8'h00);
    send_txn(KIND_RX_BYTE, 8'hFF);
    send_txn(KIND_SW_PEEK, 8'h00);
    send_txn(KIND_SW_POP, 8'h00);
    send_txn(KIND_SW_POP, 8'h00);
    send_txn(KIND_SW_POP, 8'h00);     // pop on an empty ring: stale slot, count wraps
    send_txn(KIND_RX_BYTE, 8'h5A);
    send_txn(KIND_SW_WRITE, 8'h3C);
    send_txn(KIND_SW_WRITE, 8'hC3);   // push to a full ring overwrites the slot
    send_txn(KIND_START, 8'h00);
    repeat (3) send_txn(KIND_TX_READY, 8'h00);
    send_txn(KIND_SW_WRITE, 8'h80);
    send_txn(KIND_TX_READY, 8'h00);   // data waiting but sending is off
    send_txn(KIND_START, 8'h00);
    repeat (2) send_txn(KIND_TX_READY, 8'h00);

    // Random phases, each on its own ring sizes; every fourth runs without idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < NUM_PHASES - 2) write_sizes(rx_sizes[p], tx_sizes[p]);
      else write_sizes(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
      calm_in  = (p % 4 == 3);
      calm_out = (p % 4 == 3);
      run_random(ITEMS_PER_PHASE, p % 3);
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: uart_ring_buffer_engine.f
hw/rtl/urbe_pkg.sv
hw/rtl/urbe_mod_unit.sv
hw/rtl/uart_ring_buffer_engine.sv
tb/urbe_checker.sv
tb/tb_top.sv
